// ===== design/ftsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ftsc_pkg: shared types and constants of the float to sample converter
// Holds register indexes, the depth reset value and field widths.
// ----------------------------------------------------------------------------
package ftsc_pkg;
    localparam int unsigned FloatW   = 32;
    localparam int unsigned SampleW  = 32;
    localparam int unsigned DepthW   = 6;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 6;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SAMPLE_DEPTH   = 2'd0,
        REG_SIGNED_SAMPLES = 2'd1,
        REG_NLT_TYPE3      = 2'd2
    } t_cfg_reg;

    localparam logic [DepthW-1:0] BitDepthReset = 6'd8;
endpackage

// ===== design/ftsc_in_if.sv =====
// ----------------------------------------------------------------------------
// ftsc_in_if: input channel
// Carries one binary32 sample and its last flag with valid and ready.
// ----------------------------------------------------------------------------
interface ftsc_in_if import ftsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FloatW-1:0] float_bits;
    logic              last_in;
    modport source (output valid, output float_bits, output last_in, input ready);
    modport sink   (input valid, input float_bits, input last_in, output ready);
endinterface

// ===== design/ftsc_out_if.sv =====
// ----------------------------------------------------------------------------
// ftsc_out_if: output channel
// Carries one integer sample and its last flag with valid and ready.
// ----------------------------------------------------------------------------
interface ftsc_out_if import ftsc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SampleW-1:0] int_sample;
    logic                      last_out;
    modport source (output valid, output int_sample, output last_out, input ready);
    modport sink   (input valid, input int_sample, input last_out, output ready);
endinterface

// ===== design/float_to_sample_converter_unit.sv =====
// ----------------------------------------------------------------------------
// float_to_sample_converter_unit: binary32 to integer sample conversion
// Scales by 2^depth, rounds to nearest even, clamps, then offsets or maps by mode.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  i_in      sink       float_bits[31:0], last_in
//  o_out     source     int_sample[31:0], last_out
//  config    write      i_cfg_we, i_cfg_idx[1:0], i_cfg_data[5:0]
//
// Four register stages: decode, shift, round and clamp, offset and output.
// One transfer per clock is sustained while the output is not stalled.
// All stages advance together when the output register is free or taken,
// so a stall holds every stage and nothing is lost or repeated.
// Reset clears the valid bits and the sign and type 3 registers, and sets the depth to its reset value.
// ----------------------------------------------------------------------------
module float_to_sample_converter_unit import ftsc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    ftsc_in_if.sink             i_in,
    ftsc_out_if.source          o_out
);
    logic [DepthW-1:0] r_depth;
    logic              r_signed;
    logic              r_nlt3;
    logic [5:0]        w_bd;

    logic [3:0] r_vld;
    logic       w_adv;

    // Stage 1 registers.
    logic        r1_sgn, r1_nan, r1_inf, r1_big, r1_zero, r1_last;
    logic [23:0] r1_m;
    logic [4:0]  r1_sh;
    logic        r1_left;
    // Stage 2 registers.
    logic        r2_sgn, r2_nan, r2_inf, r2_last;
    logic [40:0] r2_mag;
    logic        r2_rnd;
    // Stage 3 registers.
    logic [31:0] r3_val;
    logic        r3_last;
    // Stage 4 registers.
    logic [31:0] r4_val;
    logic        r4_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= BitDepthReset;
            r_signed <= 1'b0;
            r_nlt3   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SAMPLE_DEPTH:   r_depth  <= i_cfg_data;
                REG_SIGNED_SAMPLES: r_signed <= i_cfg_data[0];
                REG_NLT_TYPE3:      r_nlt3   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_bd = (r_depth == '0) ? 6'd1 :
                  (r_depth > 6'd32) ? 6'd32 : r_depth;

    assign w_adv      = !r_vld[3] || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[2:0], i_in.valid};
        end
    end

    // Stage 1: decode and compute the shift e2 = exp - 150 + bd.
    logic [7:0]        w_ex;
    logic signed [9:0] w_e2;
    always_comb begin
        w_ex = i_in.float_bits[30:23];
        w_e2 = $signed({2'b00, (w_ex != 8'd0) ? w_ex : 8'd1}) - 10'sd150
             + $signed({4'b0000, w_bd});
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_sgn  <= i_in.float_bits[31];
            r1_nan  <= (w_ex == 8'hFF) && (i_in.float_bits[22:0] != '0);
            r1_inf  <= (w_ex == 8'hFF) && (i_in.float_bits[22:0] == '0);
            r1_m    <= {w_ex != 8'd0, i_in.float_bits[22:0]};
            r1_last <= i_in.last_in;
            r1_left <= !w_e2[9];
            r1_big  <= !w_e2[9] && (w_e2 >= 10'sd17);
            // Right shifts of 26 or more always give zero.
            r1_zero <= w_e2[9] && (w_e2 <= -10'sd26);
            r1_sh   <= w_e2[9] ? 5'(-w_e2) : 5'(w_e2);
        end
    end

    // Stage 2: shift and form the round-up decision. A left shift of 17
    // or more is far beyond any clamp limit. The remainder and the half
    // point are one bit wider than the mantissa so that a right shift of
    // 25 keeps its half point of 2^24.
    logic [40:0] w_shl;
    logic [23:0] w_q;
    logic [24:0] w_rem, w_half;
    logic        w_up;
    always_comb begin
        w_shl  = {17'd0, r1_m} << r1_sh;
        w_q    = r1_m >> r1_sh;
        w_rem  = {1'b0, r1_m} & ((25'd1 << r1_sh) - 25'd1);
        w_half = 25'd1 << (r1_sh - 5'd1);
        w_up   = (r1_sh != 5'd0) &&
                 ((w_rem > w_half) || ((w_rem == w_half) && w_q[0]));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_sgn  <= r1_sgn;
            r2_nan  <= r1_nan;
            r2_inf  <= r1_inf || (r1_big && r1_m != '0);
            r2_last <= r1_last;
            if (r1_left) begin
                r2_mag <= w_shl;
                r2_rnd <= 1'b0;
            end else if (r1_zero) begin
                r2_mag <= '0;
                r2_rnd <= 1'b0;
            end else begin
                r2_mag <= {17'd0, w_q};
                r2_rnd <= w_up;
            end
        end
    end

    // Stage 3: round, negate and clamp.
    logic [40:0]        w_mag;
    logic signed [41:0] w_val, w_lo, w_hi;
    logic [31:0]        w_clamp;
    always_comb begin
        w_mag = r2_mag + {40'd0, r2_rnd};
        w_val = r2_sgn ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        w_hi  = $signed(42'd1 << (w_bd - 6'd1)) - 42'sd1;
        w_lo  = -$signed(42'd1 << (w_bd - 6'd1));
        if (r2_nan)
            w_clamp = 32'h8000_0000;
        else if (r2_inf)
            w_clamp = r2_sgn ? w_lo[31:0] : w_hi[31:0];
        else if (w_val < w_lo)
            w_clamp = w_lo[31:0];
        else if (w_val > w_hi)
            w_clamp = w_hi[31:0];
        else
            w_clamp = w_val[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_val  <= w_clamp;
            r3_last <= r2_last;
        end
    end

    // Stage 4: half-range offset or the type 3 mapping of negatives.
    logic [31:0] w_halfr, w_out;
    always_comb begin
        w_halfr = 32'(33'd1 << (w_bd - 6'd1));
        if (r_signed) begin
            if (r_nlt3 && r3_val[31])
                w_out = (32'd0 - (w_halfr + 32'd1)) - r3_val;
            else
                w_out = r3_val;
        end else begin
            w_out = r3_val + w_halfr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_val  <= w_out;
            r4_last <= r3_last;
        end
    end

    assign o_out.valid      = r_vld[3];
    assign o_out.int_sample = $signed(r4_val);
    assign o_out.last_out   = r4_last;
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench of the float to sample converter
// Feeds binary32 samples with random valid gaps and ready stalls, predicts
// each integer sample in the bench and compares every output transfer
// against the oldest prediction, over several register settings.
// ----------------------------------------------------------------------------
module tb;
    import ftsc_pkg::*;

    typedef struct packed {
        logic [FloatW-1:0] float_bits;
        logic              last_in;
    } t_in_item;

    typedef struct packed {
        logic [SampleW-1:0] int_sample;
        logic               last_out;
    } t_out_item;

    localparam int WatchdogLimit = 4000;
    localparam int LatencyWait   = 12;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    ftsc_in_if  in_ch ();
    ftsc_out_if out_ch ();

    float_to_sample_converter_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // Bench copy of the configuration registers.
    logic [DepthW-1:0] depth_reg;
    logic              signed_reg;
    logic              type3_reg;

    t_in_item  pending_samples[$];
    t_out_item expected_samples[$];

    int  n_errors;
    int  n_checked;
    int  n_settings;
    int  idle_cycles;
    int  send_gap;
    int  recv_gap;
    int  hold_off;
    bit  gaps_on;
    bit  hold_request;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Rounded, clamped and offset sample for one binary32 value.
    function automatic logic [SampleW-1:0] convert_sample(logic [FloatW-1:0] f);
        int unsigned       bd;
        logic              sgn;
        logic [7:0]        ex;
        logic [63:0]       m;
        logic [63:0]       mag;
        logic [63:0]       q;
        logic [63:0]       r;
        logic [63:0]       halfr;
        longint            lo;
        longint            hi;
        longint            val;
        int                e2;
        int                s;
        logic [31:0]       u;
        logic [31:0]       half;
        bd = (depth_reg == 0) ? 1 : (depth_reg > 32) ? 32 : depth_reg;
        sgn = f[31];
        ex = f[30:23];
        lo = -(64'sd1 <<< (bd - 1));
        hi = (64'sd1 <<< (bd - 1)) - 1;
        half = 32'(64'd1 << (bd - 1));
        if (ex == 8'hFF) begin
            if (f[22:0] != 0) u = 32'h8000_0000;
            else u = sgn ? 32'(lo) : 32'(hi);
        end else begin
            m = (ex != 0) ? {41'd1, f[22:0]} : {41'd0, f[22:0]};
            e2 = int'((ex != 0) ? ex : 8'd1) - 150 + int'(bd);
            if (m == 0) begin
                mag = 0;
            end else if (e2 >= 0) begin
                mag = (e2 >= 40) ? (64'd1 << 40) : (m << e2);
            end else begin
                s = -e2;
                if (s >= 26) begin
                    mag = 0;
                end else begin
                    q = m >> s;
                    r = m & ((64'd1 << s) - 1);
                    halfr = 64'd1 << (s - 1);
                    if (r > halfr || (r == halfr && q[0])) q = q + 1;
                    mag = q;
                end
            end
            val = sgn ? -longint'(mag) : longint'(mag);
            if (val < lo) val = lo;
            if (val > hi) val = hi;
            u = 32'(val);
        end
        if (signed_reg) begin
            if (type3_reg && u[31]) u = (32'd0 - (half + 32'd1)) - u;
        end else begin
            u = u + half;
        end
        return u;
    endfunction

    task automatic queue_sample(logic [FloatW-1:0] f, logic last);
        t_in_item  it;
        t_out_item ex;
        it.float_bits = f;
        it.last_in = last;
        ex.int_sample = convert_sample(f);
        ex.last_out = last;
        pending_samples.push_back(it);
        expected_samples.push_back(ex);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CfgDataW-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SAMPLE_DEPTH:   depth_reg = data;
            REG_SIGNED_SAMPLES: signed_reg = data[0];
            REG_NLT_TYPE3:      type3_reg = data[0];
            default: ;
        endcase
    endtask

    task automatic set_mode(logic [CfgDataW-1:0] bd, logic sg, logic t3);
        write_reg(REG_SAMPLE_DEPTH, bd);
        write_reg(REG_SIGNED_SAMPLES, {5'd0, sg});
        write_reg(REG_NLT_TYPE3, {5'd0, t3});
        n_settings++;
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (LatencyWait) @(posedge i_clk);
    endtask

    // Mostly values near the nominal range, with fully random patterns too.
    function automatic logic [FloatW-1:0] random_float();
        logic [FloatW-1:0] f;
        f = $urandom;
        case ($urandom_range(0, 9))
            0, 1:    ;
            2:       f[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            3:       f[22:0] = $urandom_range(0, 1) ? 23'h400000 : 23'h0;
            default: f[30:23] = $urandom_range(100, 130);
        endcase
        return f;
    endfunction

    // Driver: offers queued samples, with random gaps while gaps_on is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) void'(pending_samples.pop_front());
            if (in_ch.valid && !in_ch.ready) begin
                // An offered sample stays unchanged until its transfer.
                in_ch.valid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                send_gap <= $urandom_range(0, 8);
                in_ch.valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.float_bits <= pending_samples[0].float_bits;
                in_ch.last_in <= pending_samples[0].last_in;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: stalls ready at random and checks each output transfer.
    always @(posedge i_clk) begin
        t_out_item ex;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_gap <= 0;
            hold_off <= 0;
            idle_cycles <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_samples.size() == 0) begin
                    $error("output transfer with no sample expected");
                    n_errors++;
                end else begin
                    ex = expected_samples.pop_front();
                    n_checked++;
                    if (out_ch.int_sample !== ex.int_sample) begin
                        $error("int_sample: expected %h, actual %h",
                               ex.int_sample, out_ch.int_sample);
                        n_errors++;
                    end
                    if (out_ch.last_out !== ex.last_out) begin
                        $error("last_out: expected %b, actual %b",
                               ex.last_out, out_ch.last_out);
                        n_errors++;
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (hold_request && hold_off == 0) begin
                hold_off <= 60;
                out_ch.ready <= 1'b0;
            end else if (hold_off > 1) begin
                hold_off <= hold_off - 1;
                out_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_ch.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(0, 8);
                out_ch.ready <= 1'b0;
            end else begin
                hold_off <= 0;
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [FloatW-1:0] dir_vals[$];
        int                n;
        n_errors = 0;
        n_checked = 0;
        n_settings = 0;
        gaps_on = 1'b1;
        hold_request = 1'b0;
        depth_reg = BitDepthReset;
        signed_reg = 1'b0;
        type3_reg = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_SAMPLE_DEPTH;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.float_bits = '0;
        in_ch.last_in = 1'b0;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zeros, halves, ties, infinities, NaNs, subnormals, huge and tiny.
        dir_vals = '{32'h0000_0000, 32'h8000_0000, 32'h3F00_0000, 32'hBF00_0000,
                     32'h3EFF_FFFF, 32'hBEFF_FFFF, 32'h3B80_0000, 32'h3BC0_0000,
                     32'h3C20_0000, 32'hBBC0_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001,
                     32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F80_0000,
                     32'h3B7F_FFFF, 32'h3EFF_FFFE};
        // Reset settings first: no register write yet.
        foreach (dir_vals[k]) queue_sample(dir_vals[k], k[0]);
        n_settings++;
        wait_drained();

        foreach (dir_vals[k]) begin
            set_mode(6'(k * 3), k[0], k[1]);
            queue_sample(dir_vals[k], k[1]);
            queue_sample(random_float(), 1'b1);
            wait_drained();
        end

        // Random phases over many settings, extremes included.
        for (int p = 0; p < 12; p++) begin
            case (p)
                0:       set_mode(6'd1, 1'b1, 1'b1);
                1:       set_mode(6'd32, 1'b1, 1'b1);
                2:       set_mode(6'd63, 1'b0, 1'b0);
                3:       set_mode(6'd0, 1'b1, 1'b0);
                default: set_mode(6'($urandom_range(0, 63)), 1'($urandom),
                                  1'($urandom));
            endcase
            if (p == 10) gaps_on = 1'b0;
            // The receiver holds off while the phase is queued, so the pipeline fills and stalls.
            if (p == 5) begin
                hold_request = 1'b1;
                wait (hold_off != 0);
                hold_request = 1'b0;
            end
            n = 40;
            for (int k = 0; k < n; k++) queue_sample(random_float(), 1'($urandom));
            wait_drained();
        end

        $display("checked %0d samples over %0d register settings", n_checked, n_settings);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
